// ----- sv/cbw_pkg.sv -----
// Shared widths, segment kind codes and the coefficient table of the cubic B-spline weight block.
package cbw_pkg;

	localparam int FRAC_BITS = 16;
	localparam int T_W       = 17;
	localparam int KIND_W    = 3;
	localparam int W_W       = 17;

	localparam int T2_W = 2 * FRAC_BITS + 1;
	localparam int T3_W = 3 * FRAC_BITS + 1;

	localparam int C_W  = 7;
	localparam int CM_W = 6;

	localparam int M3_W = 3 * FRAC_BITS + 6;
	localparam int M2_W = 2 * FRAC_BITS + 6;
	localparam int M1_W = FRAC_BITS + 6;

	localparam int A_W  = 3 * FRAC_BITS + 8;
	localparam int AH_W = A_W - 2 * FRAC_BITS;
	localparam int HI_W = FRAC_BITS + 10;

	// divide by 12 as shift by 2, then multiply by a reciprocal of 3
	localparam int Y_W       = HI_W - 3;
	localparam int RECIP_SH  = 22;
	localparam int RECIP_K   = ((1 << RECIP_SH) - 1) / 3;
	localparam int K_W       = 21;
	localparam int P_W       = Y_W + K_W;
	localparam int Q_W       = P_W - RECIP_SH;
	localparam int QX_W      = Q_W + 2;

	localparam int ONE = 1 << FRAC_BITS;

	localparam logic [KIND_W-1:0] KIND_UNIFORM     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_FIRST       = 3'd1;
	localparam logic [KIND_W-1:0] KIND_SECOND      = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SECOND_LAST = 3'd3;
	localparam logic [KIND_W-1:0] KIND_LAST        = 3'd4;

	// polynomial coefficients over 12: t^3, t^2, t, 1
	typedef struct packed {
		logic signed [C_W-1:0] c3;
		logic signed [C_W-1:0] c2;
		logic signed [C_W-1:0] c1;
		logic signed [C_W-1:0] c0;
	} cbw_coef_t;

	typedef struct packed {
		logic ld_s4;
		logic ld_s5;
		logic ld_s6;
		logic ld_s7;
		logic ld_s8;
	} cbw_lane_ctrl_t;

	function automatic cbw_coef_t coef_lookup(input logic [KIND_W-1:0] kind,
		input logic [1:0] w);
		cbw_coef_t c;
		c = '{c3: 7'sd0, c2: 7'sd0, c1: 7'sd0, c0: 7'sd0};
		case (kind)
			KIND_FIRST: begin
				case (w)
					2'd0: c = '{c3: -7'sd12, c2: 7'sd36, c1: -7'sd36, c0: 7'sd12};
					2'd1: c = '{c3: 7'sd21, c2: -7'sd54, c1: 7'sd36, c0: 7'sd0};
					2'd2: c = '{c3: -7'sd11, c2: 7'sd18, c1: 7'sd0, c0: 7'sd0};
					default: c = '{c3: 7'sd2, c2: 7'sd0, c1: 7'sd0, c0: 7'sd0};
				endcase
			end
			KIND_SECOND: begin
				case (w)
					2'd0: c = '{c3: -7'sd3, c2: 7'sd9, c1: -7'sd9, c0: 7'sd3};
					2'd1: c = '{c3: 7'sd7, c2: -7'sd15, c1: 7'sd3, c0: 7'sd7};
					2'd2: c = '{c3: -7'sd6, c2: 7'sd6, c1: 7'sd6, c0: 7'sd2};
					default: c = '{c3: 7'sd2, c2: 7'sd0, c1: 7'sd0, c0: 7'sd0};
				endcase
			end
			KIND_SECOND_LAST: begin
				case (w)
					2'd0: c = '{c3: -7'sd2, c2: 7'sd6, c1: -7'sd6, c0: 7'sd2};
					2'd1: c = '{c3: 7'sd6, c2: -7'sd12, c1: 7'sd0, c0: 7'sd8};
					2'd2: c = '{c3: -7'sd7, c2: 7'sd6, c1: 7'sd6, c0: 7'sd2};
					default: c = '{c3: 7'sd3, c2: 7'sd0, c1: 7'sd0, c0: 7'sd0};
				endcase
			end
			KIND_LAST: begin
				case (w)
					2'd0: c = '{c3: -7'sd2, c2: 7'sd6, c1: -7'sd6, c0: 7'sd2};
					2'd1: c = '{c3: 7'sd11, c2: -7'sd15, c1: -7'sd3, c0: 7'sd7};
					2'd2: c = '{c3: -7'sd21, c2: 7'sd9, c1: 7'sd9, c0: 7'sd3};
					default: c = '{c3: 7'sd12, c2: 7'sd0, c1: 7'sd0, c0: 7'sd0};
				endcase
			end
			default: begin
				case (w)
					2'd0: c = '{c3: -7'sd2, c2: 7'sd6, c1: -7'sd6, c0: 7'sd2};
					2'd1: c = '{c3: 7'sd6, c2: -7'sd12, c1: 7'sd0, c0: 7'sd8};
					2'd2: c = '{c3: -7'sd6, c2: 7'sd6, c1: 7'sd6, c0: 7'sd2};
					default: c = '{c3: 7'sd2, c2: 7'sd0, c1: 7'sd0, c0: 7'sd0};
				endcase
			end
		endcase
		return c;
	endfunction

endpackage

// ----- sv/cbw_in_if.sv -----
// Request channel carrying one curve parameter and segment kind.
interface cbw_in_if;
	logic                        valid;
	logic                        ready;
	logic [cbw_pkg::T_W-1:0]     param_t;
	logic [cbw_pkg::KIND_W-1:0]  segment_kind;

	modport source(output valid, output param_t, output segment_kind, input ready);
	modport sink(input valid, input param_t, input segment_kind, output ready);
endinterface

// ----- sv/cbw_out_if.sv -----
// Result channel carrying the four blend weights.
interface cbw_out_if;
	logic                    valid;
	logic                    ready;
	logic [cbw_pkg::W_W-1:0] weight_0;
	logic [cbw_pkg::W_W-1:0] weight_1;
	logic [cbw_pkg::W_W-1:0] weight_2;
	logic [cbw_pkg::W_W-1:0] weight_3;

	modport source(output valid, output weight_0, output weight_1, output weight_2,
		output weight_3, input ready);
	modport sink(input valid, input weight_0, input weight_1, input weight_2,
		input weight_3, output ready);
endinterface

// ----- sv/cbw_lane.sv -----
// One weight lane: coefficient products, exact sum, divide by 12 with rounding, saturation.
module cbw_lane (
	input  logic                           clk,
	input  cbw_pkg::cbw_lane_ctrl_t        ctrl,
	input  cbw_pkg::cbw_coef_t             coef,
	input  logic [cbw_pkg::T_W-1:0]        t,
	input  logic [cbw_pkg::T2_W-1:0]       t2,
	input  logic [cbw_pkg::T3_W-1:0]       t3,
	output logic [cbw_pkg::W_W-1:0]        weight
);

	function automatic logic [cbw_pkg::CM_W-1:0] cmag(input logic signed [cbw_pkg::C_W-1:0] c);
		logic signed [cbw_pkg::C_W-1:0] n;
		n = -c;
		return c[cbw_pkg::C_W-1] ? n[cbw_pkg::CM_W-1:0] : c[cbw_pkg::CM_W-1:0];
	endfunction

	// s4: magnitudes of the four terms, signs kept aside
	logic [3:0]                  sg_s4;
	logic [cbw_pkg::M3_W-1:0]    m3_s4;
	logic [cbw_pkg::M2_W-1:0]    m2_s4;
	logic [cbw_pkg::M1_W-1:0]    m1_s4;
	logic [cbw_pkg::CM_W-1:0]    m0_s4;

	always_ff @(posedge clk) begin
		if (ctrl.ld_s4) begin
			sg_s4 <= {coef.c3[cbw_pkg::C_W-1], coef.c2[cbw_pkg::C_W-1],
				coef.c1[cbw_pkg::C_W-1], coef.c0[cbw_pkg::C_W-1]};
			m3_s4 <= cbw_pkg::M3_W'(cmag(coef.c3)) * cbw_pkg::M3_W'(t3);
			m2_s4 <= cbw_pkg::M2_W'(cmag(coef.c2)) * cbw_pkg::M2_W'(t2);
			m1_s4 <= cbw_pkg::M1_W'(cmag(coef.c1)) * cbw_pkg::M1_W'(t);
			m0_s4 <= cmag(coef.c0);
		end
	end

	// s5: a holds the terms with nonzero low 2F bits, b the rest already scaled by 2^-2F
	logic signed [cbw_pkg::A_W-1:0]  e3, e2, a_s5;
	logic signed [cbw_pkg::HI_W-1:0] e1, e0, b_s5;

	always_comb begin
		e3 = $signed(cbw_pkg::A_W'(m3_s4));
		e2 = $signed(cbw_pkg::A_W'({m2_s4, {cbw_pkg::FRAC_BITS{1'b0}}}));
		e1 = $signed(cbw_pkg::HI_W'(m1_s4));
		e0 = $signed(cbw_pkg::HI_W'({m0_s4, {cbw_pkg::FRAC_BITS{1'b0}}}));
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_s5) begin
			a_s5 <= (sg_s4[3] ? -e3 : e3) + (sg_s4[2] ? -e2 : e2);
			b_s5 <= (sg_s4[1] ? -e1 : e1) + (sg_s4[0] ? -e0 : e0);
		end
	end

	// s6: floor of the exact value times 12, plus 6 for round to nearest
	logic signed [cbw_pkg::AH_W-1:0] ah;
	logic signed [cbw_pkg::HI_W-1:0] x_s6;

	assign ah = a_s5[cbw_pkg::A_W-1:2*cbw_pkg::FRAC_BITS];

	always_ff @(posedge clk) begin
		if (ctrl.ld_s6) begin
			x_s6 <= cbw_pkg::HI_W'(ah) + b_s5 + cbw_pkg::HI_W'(6);
		end
	end

	// s7: x/4 times reciprocal of 3
	logic                       neg_s7;
	logic [cbw_pkg::Y_W-1:0]    y, y_s7;
	logic [cbw_pkg::P_W-1:0]    p_s7;

	assign y = x_s6[cbw_pkg::HI_W-1] ? '0 : x_s6[cbw_pkg::Y_W+1:2];

	always_ff @(posedge clk) begin
		if (ctrl.ld_s7) begin
			neg_s7 <= x_s6[cbw_pkg::HI_W-1];
			y_s7   <= y;
			p_s7   <= cbw_pkg::P_W'(y) * cbw_pkg::P_W'(cbw_pkg::RECIP_K);
		end
	end

	// s8: the estimate is at most one low; fix it, then saturate
	logic [cbw_pkg::QX_W-1:0] q, q3p, qc;

	always_comb begin
		q   = cbw_pkg::QX_W'(p_s7[cbw_pkg::P_W-1:cbw_pkg::RECIP_SH]);
		q3p = {q[cbw_pkg::QX_W-2:0], 1'b0} + q + cbw_pkg::QX_W'(3);
		qc  = (q3p <= cbw_pkg::QX_W'(y_s7)) ? q + cbw_pkg::QX_W'(1) : q;
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_s8) begin
			if (neg_s7) begin
				weight <= '0;
			end else if (qc > cbw_pkg::QX_W'(cbw_pkg::ONE)) begin
				weight <= cbw_pkg::W_W'(cbw_pkg::ONE);
			end else begin
				weight <= qc[cbw_pkg::W_W-1:0];
			end
		end
	end

endmodule

// ----- sv/cubic_bspline_basis_weights.sv -----
// Top level: cubic B-spline blend weights, eight-stage pipeline, one request per cycle while the output is not stalled.
//
//  channel   role    payload
//  sample    sink    param_t[16:0] Q1.16, segment_kind[2:0]
//  weights   source  weight_0..weight_3 [16:0] Q1.16
//
// Throughput one request per clock while the weights channel is not stalled.
// Stages: clamp, t^2 multiply, t^3 multiply, coefficient products, two adds, the
// reciprocal multiply that divides by 12, then correction and saturation.
// Reset clears only the stage valid bits; payload registers are left as they are.
// A full stage holds when the one after it is full and not moving, so a stalled
// result still lets the empty stages behind it take new requests.
module cubic_bspline_basis_weights (
	input  logic        clk,
	input  logic        arst_n,
	cbw_in_if.sink      sample,
	cbw_out_if.source   weights
);

	localparam int NST = 8;

	logic [NST:1]   v;
	logic [NST+1:1] rdy;

	always_comb begin
		rdy[NST+1] = weights.ready;
		for (int i = NST; i >= 1; i--) begin
			rdy[i] = !v[i] || rdy[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (rdy[1]) begin
				v[1] <= sample.valid;
			end
			for (int i = 2; i <= NST; i++) begin
				if (rdy[i]) begin
					v[i] <= v[i-1];
				end
			end
		end
	end

	assign sample.ready = rdy[1];

	// s1: clamp t to one, unknown kinds fall back to uniform
	logic [cbw_pkg::T_W-1:0]    t_s1, t_s2, t_s3;
	logic [cbw_pkg::KIND_W-1:0] kind_s1, kind_s2, kind_s3;
	logic [cbw_pkg::T2_W-1:0]   t2_s2, t2_s3;
	logic [cbw_pkg::T3_W-1:0]   t3_s3;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			t_s1    <= (sample.param_t > cbw_pkg::T_W'(cbw_pkg::ONE)) ?
				cbw_pkg::T_W'(cbw_pkg::ONE) : sample.param_t;
			kind_s1 <= (sample.segment_kind > cbw_pkg::KIND_LAST) ?
				cbw_pkg::KIND_UNIFORM : sample.segment_kind;
		end
		if (rdy[2]) begin
			t_s2    <= t_s1;
			kind_s2 <= kind_s1;
			t2_s2   <= cbw_pkg::T2_W'(t_s1) * cbw_pkg::T2_W'(t_s1);
		end
		if (rdy[3]) begin
			t_s3    <= t_s2;
			kind_s3 <= kind_s2;
			t2_s3   <= t2_s2;
			t3_s3   <= cbw_pkg::T3_W'(t2_s2) * cbw_pkg::T3_W'(t_s2);
		end
	end

	cbw_pkg::cbw_lane_ctrl_t lane_ctrl;

	assign lane_ctrl = '{ld_s4: rdy[4], ld_s5: rdy[5], ld_s6: rdy[6], ld_s7: rdy[7],
		ld_s8: rdy[8]};

	logic [cbw_pkg::W_W-1:0] w_s8 [4];

	for (genvar k = 0; k < 4; k++) begin : g_lane
		cbw_pkg::cbw_coef_t coef;

		assign coef = cbw_pkg::coef_lookup(kind_s3, 2'(k));

		cbw_lane u_lane (
			.clk    (clk),
			.ctrl   (lane_ctrl),
			.coef   (coef),
			.t      (t_s3),
			.t2     (t2_s3),
			.t3     (t3_s3),
			.weight (w_s8[k])
		);
	end

	assign weights.valid    = v[NST];
	assign weights.weight_0 = w_s8[0];
	assign weights.weight_1 = w_s8[1];
	assign weights.weight_2 = w_s8[2];
	assign weights.weight_3 = w_s8[3];

`ifndef SYNTHESIS
	localparam int SUM_W = cbw_pkg::W_W + 2;

	logic [SUM_W-1:0] wsum;

	assign wsum = SUM_W'(w_s8[0]) + SUM_W'(w_s8[1]) + SUM_W'(w_s8[2]) + SUM_W'(w_s8[3]);

	// weights form a partition of unity up to rounding of each term
	a_unity: assert property (@(posedge clk) disable iff (!arst_n)
		weights.valid |-> (wsum >= SUM_W'(cbw_pkg::ONE - 1) &&
			wsum <= SUM_W'(cbw_pkg::ONE + 2)))
		else $error("blend weights do not sum to one");

	// requests are refused only when every stage is occupied
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> (&v))
		else $error("request refused with a free pipeline stage");

	// a blocked first stage keeps its contents
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v[1] && !rdy[2]) |=> (v[1] && $stable(t_s1) && $stable(kind_s1)))
		else $error("stalled stage lost its contents");
`endif

endmodule
